>>> rtl/core/stbs_pkg.sv
// shared types and codes for the sorted table search block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package stbs_pkg;

	localparam int VALUE_W = 32;
	localparam int POS_W   = 7;

	// command codes as they arrive on the input stream
	localparam logic [1:0] CMD_CLEAR  = 2'd0;
	localparam logic [1:0] CMD_APPEND = 2'd1;
	localparam logic [1:0] CMD_SEARCH = 2'd2;

	typedef enum logic [1:0] {
		OP_CLEAR,
		OP_APPEND,
		OP_SEARCH,
		OP_NOP
	} op_t;

	typedef struct packed {
		op_t                       op;
		logic signed [VALUE_W-1:0] value;
	} item_t;

endpackage

`default_nettype wire

>>> rtl/core/stbs_front.sv
// front end: accepts input beats, decodes the command and queues the item
// depends on stbs_pkg
`timescale 1ns / 1ps
`default_nettype none

module stbs_front (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          s_axis_tvalid,
	output logic                         s_axis_tready,
	input  wire  [31:0]                  s_axis_tdata,  // value[31:0]
	input  wire  [1:0]                   s_axis_tuser,  // command[1:0]
	output logic                         q_valid,
	output stbs_pkg::item_t              q_item,
	input  wire                          q_pop
);
	import stbs_pkg::*;

	item_t      slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	item_t      in_item;
	logic       push;
	logic       pop;

	always_comb begin
		in_item.value = $signed(s_axis_tdata);
		case (s_axis_tuser)
			CMD_CLEAR:  in_item.op = OP_CLEAR;
			CMD_APPEND: in_item.op = OP_APPEND;
			CMD_SEARCH: in_item.op = OP_SEARCH;
			default:    in_item.op = OP_NOP;
		endcase
	end

	assign s_axis_tready = (fill_q != 2'd2);
	assign q_valid       = (fill_q != 2'd0);
	assign q_item        = slot_q[rd_ptr_q];
	assign push          = s_axis_tvalid && s_axis_tready;
	assign pop           = q_pop && q_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/stbs_back.sv
// back end: table memory, fill count, binary search sequencer, result register
// depends on stbs_pkg
`timescale 1ns / 1ps
`default_nettype none

module stbs_back #(
	parameter int DEPTH = 128
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                q_valid,
	input  stbs_pkg::item_t    q_item,
	output logic               q_pop,
	input  wire                cfg_valid,
	output logic               cfg_ready,
	input  wire                cfg_data,
	output logic               m_axis_tvalid,
	input  wire                m_axis_tready,
	output logic [7:0]         m_axis_tdata,  // position[6:0], zero pad
	output logic [1:0]         m_axis_tuser   // found[0], status[1]
);
	import stbs_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PROBE,
		ST_CMP,
		ST_FINISH
	} state_t;

	state_t                     state_q;
	logic                       desc_q;
	logic [CW-1:0]              count_q;
	logic [CW-1:0]              lo_q;
	logic [CW-1:0]              hi_q;
	logic [AW-1:0]              mid_q;
	logic signed [VALUE_W-1:0]  key_q;
	logic signed [VALUE_W-1:0]  rdata_q;
	logic                       found_q;
	logic [AW-1:0]              pos_q;
	logic                       m_valid_q;
	logic                       m_found_q;
	logic                       m_status_q;
	logic [POS_W-1:0]           m_pos_q;

	logic signed [VALUE_W-1:0]  mem [DEPTH];

	logic                       out_free;
	logic                       res_load;
	logic                       mem_we;
	logic                       rd_en;
	logic [CW-1:0]              span;
	logic [CW-1:0]              mid_full;
	logic [AW-1:0]              mid;
	logic [CW-1:0]              mid_next;
	logic                       go_right;
	logic                       table_full;
	logic [AW+POS_W-1:0]        pos_ext;

	assign cfg_ready  = 1'b1;
	assign out_free   = !m_valid_q || m_axis_tready;
	assign q_pop      = (state_q == ST_IDLE) && out_free;
	assign table_full = (count_q >= CW'(DEPTH));
	assign mem_we     = q_pop && q_valid && (q_item.op == OP_APPEND) && !table_full;
	assign rd_en      = (state_q == ST_PROBE);

	// a result enters the output register this cycle
	assign res_load = (q_pop && q_valid && (q_item.op != OP_SEARCH)) ||
	                  ((state_q == ST_FINISH) && out_free);

	// midpoint of the half-open window, lower middle
	assign span     = hi_q - lo_q - CW'(1);
	assign mid_full = lo_q + (span >> 1);
	assign mid      = mid_full[AW-1:0];
	assign mid_next = CW'(mid_q) + CW'(1);
	assign go_right = desc_q ? (rdata_q > key_q) : (rdata_q < key_q);
	assign pos_ext  = {{POS_W{1'b0}}, pos_q};

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {1'b0, m_pos_q};
	assign m_axis_tuser  = {m_status_q, m_found_q};

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[count_q[AW-1:0]] <= q_item.value;
		end
		if (rd_en) begin
			rdata_q <= mem[mid];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			desc_q     <= 1'b1;
			count_q    <= '0;
			m_valid_q  <= 1'b0;
			m_found_q  <= 1'b0;
			m_status_q <= 1'b0;
			m_pos_q    <= '0;
			lo_q       <= '0;
			hi_q       <= '0;
			mid_q      <= '0;
			key_q      <= '0;
			found_q    <= 1'b0;
			pos_q      <= '0;
		end else begin
			if (cfg_valid) begin
				desc_q <= cfg_data;
			end
			if (res_load) begin
				m_valid_q <= 1'b1;
			end else if (m_valid_q && m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (q_pop && q_valid) begin
						case (q_item.op)
							OP_SEARCH: begin
								lo_q    <= '0;
								hi_q    <= count_q;
								key_q   <= q_item.value;
								found_q <= 1'b0;
								pos_q   <= '0;
								state_q <= (count_q == '0) ? ST_FINISH : ST_PROBE;
							end
							OP_CLEAR: begin
								count_q    <= '0;
								m_found_q  <= 1'b0;
								m_pos_q    <= '0;
								m_status_q <= 1'b0;
							end
							OP_APPEND: begin
								if (!table_full) begin
									count_q <= count_q + CW'(1);
								end
								m_found_q  <= 1'b0;
								m_pos_q    <= '0;
								m_status_q <= table_full;
							end
							default: begin
								m_found_q  <= 1'b0;
								m_pos_q    <= '0;
								m_status_q <= 1'b0;
							end
						endcase
					end
				end
				ST_PROBE: begin
					mid_q   <= mid;
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (rdata_q == key_q) begin
						found_q <= 1'b1;
						pos_q   <= mid_q;
						state_q <= ST_FINISH;
					end else if (go_right) begin
						lo_q    <= mid_next;
						state_q <= (mid_next >= hi_q) ? ST_FINISH : ST_PROBE;
					end else begin
						hi_q    <= CW'(mid_q);
						state_q <= (lo_q >= CW'(mid_q)) ? ST_FINISH : ST_PROBE;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						m_found_q  <= found_q;
						m_pos_q    <= pos_ext[POS_W-1:0];
						m_status_q <= 1'b0;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/sorted_table_binary_search.sv
// sorted table with binary search: top level, front queue plus back sequencer
// depends on stbs_pkg, stbs_front, stbs_back
// clear, append and unused codes: the beat is registered in the front queue, then its result
// in the output register; one item per cycle while the output accepts and no search runs
// search: each probe is a synchronous table read then a compare; the probe loop sets the rate
// asynchronous active-low reset empties the table and the queue, order register resets to 1
`timescale 1ns / 1ps
`default_nettype none

module sorted_table_binary_search #(
	parameter int DEPTH = 128
) (
	input  wire         clk,
	input  wire         arst_n,
	// input stream: one command beat each
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [31:0] s_axis_tdata,   // value[31:0]
	input  wire  [1:0]  s_axis_tuser,   // command[1:0]
	// order register write: 1 descending, 0 ascending
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire         cfg_data,       // descending_order
	// result stream: one beat per command
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // position[6:0], zero pad bit 7
	output logic [1:0]  m_axis_tuser    // found[0], status[1]
);
	import stbs_pkg::*;

	// decoded items waiting for the back end
	logic  q_valid;
	item_t q_item;
	logic  q_pop;

	// front decodes the command and holds up to two beats, so input keeps
	// flowing while a search runs or a result waits downstream
	stbs_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.q_valid       (q_valid),
		.q_item        (q_item),
		.q_pop         (q_pop)
	);

	// back owns the table memory, the fill count and the probe sequencer;
	// its result register decouples the output side
	stbs_back #(
		.DEPTH (DEPTH)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_item        (q_item),
		.q_pop         (q_pop),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule

`default_nettype wire

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps

// self-checking bench for the sorted table binary search block
// needs stbs_pkg and sorted_table_binary_search; predicts every result beat in a scoreboard class
module testbench;
	import stbs_pkg::*;

	localparam int     DEPTH       = 128;
	localparam int     ITEM_TARGET = 850;
	// from this many sent items on, neither side inserts random gaps or stalls
	localparam int     CALM_FROM   = 780;
	localparam longint CYCLE_LIMIT = 400000;
	localparam int     HOLD_LEN    = 300;

	// one result beat as the block should produce it
	typedef struct {
		bit               found;
		logic [POS_W-1:0] position;
		bit               status;
	} answer_t;

	// mirror of the table plus the answers still owed by the block
	class search_scoreboard;
		logic signed [VALUE_W-1:0] entries [DEPTH];
		int                        count;
		bit                        descending;
		answer_t                   answers_due[$];
		int                        errors;

		function new();
			count      = 0;
			descending = 1'b1;
			errors     = 0;
		endfunction

		function void set_order(bit desc);
			descending = desc;
		endfunction

		// apply one accepted command to the mirror and queue its answer
		function void note_command(op_t op, logic signed [VALUE_W-1:0] value);
			answer_t a;
			int      lo;
			int      hi;
			int      mid;
			bit      hit;
			a.found    = 1'b0;
			a.position = '0;
			a.status   = 1'b0;
			case (op)
				OP_CLEAR: begin
					count = 0;
				end
				OP_APPEND: begin
					if (count < DEPTH) begin
						entries[count] = value;
						count++;
					end else begin
						a.status = 1'b1;
					end
				end
				OP_SEARCH: begin
					// half-open window, probe at the lower middle
					lo  = 0;
					hi  = count;
					hit = 1'b0;
					while (lo < hi && !hit) begin
						mid = lo + (hi - 1 - lo) / 2;
						if (entries[mid] == value) begin
							hit        = 1'b1;
							a.found    = 1'b1;
							a.position = mid[POS_W-1:0];
						end else if (descending ? (entries[mid] > value)
								: (entries[mid] < value)) begin
							lo = mid + 1;
						end else begin
							hi = mid;
						end
					end
				end
				default: begin
				end
			endcase
			answers_due.push_back(a);
		endfunction

		function void check_result(bit found, logic [POS_W-1:0] position, bit status);
			answer_t a;
			if (answers_due.size() == 0) begin
				$error("result beat with no command outstanding");
				errors++;
				return;
			end
			a = answers_due.pop_front();
			if (found !== a.found) begin
				$error("found: expected %0d actual %0d", a.found, found);
				errors++;
			end
			if (position !== a.position) begin
				$error("position: expected %0d actual %0d", a.position, position);
				errors++;
			end
			if (status !== a.status) begin
				$error("status: expected %0d actual %0d", a.status, status);
				errors++;
			end
		endfunction
	endclass

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [31:0]  s_axis_tdata;   // value[31:0]
	logic [1:0]   s_axis_tuser;   // command[1:0]
	logic         cfg_valid;
	logic         cfg_ready;
	logic         cfg_data;       // descending_order
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [7:0]   m_axis_tdata;   // position[6:0], zero pad bit 7
	logic [1:0]   m_axis_tuser;   // found[0], status[1]

	search_scoreboard sb;
	int               sent_items;
	int               hold_cycles;
	bit               calm;
	longint           cycles;

	sorted_table_binary_search #(
		.DEPTH(DEPTH)
	) uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// watchdog: the run may not outlast the cycle limit
	initial begin
		cycles = 0;
		while (cycles <= CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("TEST FAILED");
		$finish;
	end

	// result side: random stall bursts, plus one long hold counted here
	initial begin
		int stall_left;
		stall_left    = 0;
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				hold_cycles--;
				m_axis_tready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				stall_left    = $urandom_range(1, 4) - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// every accepted result beat goes to the scoreboard
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tuser[0], m_axis_tdata[POS_W-1:0], m_axis_tuser[1]);
	end

	// offer one command beat; called at a falling edge, returns at one with valid still high
	task automatic send_command(input logic [1:0] cmd, input logic [VALUE_W-1:0] val);
		int gap;
		gap = 0;
		if (!calm && $urandom_range(0, 4) == 0)
			gap = $urandom_range(1, 4);
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= cmd;
		s_axis_tdata  <= val;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sb.note_command(op_t'(cmd), val);
		sent_items++;
		@(negedge clk);
	endtask

	// drop valid and let every owed result drain
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (sb.answers_due.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// order register write, only with the block idle
	task automatic write_order(input bit desc);
		cfg_valid <= 1'b1;
		cfg_data  <= desc;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.set_order(desc);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// clear, load a table in the configured order (sometimes shuffled), then search it
	task automatic table_round(input int n_entries, input int n_searches);
		int                 vals[$];
		int                 mode;
		int                 k;
		int                 idx;
		int                 r;
		logic [VALUE_W-1:0] key;
		send_command(CMD_CLEAR, $urandom);
		mode = $urandom_range(0, 3);
		for (k = 0; k < n_entries; k++) begin
			if (mode == 0)
				vals.push_back(int'($urandom_range(0, 24)) - 12);   // dense, many duplicates
			else
				vals.push_back(int'($urandom));
		end
		r = $urandom_range(0, 7);
		if (r == 0)
			vals.shuffle();   // unsorted table, probe path still checked
		else if (sb.descending)
			vals.rsort();
		else
			vals.sort();
		foreach (vals[i]) begin
			// occasional noise beat breaks the load sequence
			if (!calm && $urandom_range(0, 11) == 0)
				send_command(2'($urandom_range(0, 3)), $urandom);
			send_command(CMD_APPEND, vals[i]);
		end
		for (k = 0; k < n_searches; k++) begin
			r = $urandom_range(0, 9);
			if (vals.size() == 0 || r >= 8) begin
				key = $urandom;
			end else begin
				idx = $urandom_range(0, vals.size() - 1);
				if (r < 6)
					key = vals[idx];
				else if (r == 6)
					key = vals[idx] + 1;
				else
					key = vals[idx] - 1;
			end
			send_command(CMD_SEARCH, key);
		end
	endtask

	initial begin
		sb            = new();
		sent_items    = 0;
		hold_cycles   = 0;
		calm          = 1'b0;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = '0;
		cfg_valid     = 1'b0;
		cfg_data      = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: reset order is descending
		send_command(CMD_SEARCH, 32'd0);            // empty table
		send_command(CMD_APPEND, 32'h7FFF_FFFF);
		send_command(CMD_APPEND, 32'd100);
		send_command(CMD_APPEND, 32'd0);
		send_command(CMD_APPEND, 32'hFFFF_FFFF);
		send_command(CMD_APPEND, 32'h8000_0000);
		send_command(CMD_APPEND, 32'h8000_0000);    // duplicate at the bottom
		send_command(CMD_SEARCH, 32'h7FFF_FFFF);
		send_command(CMD_SEARCH, 32'h8000_0000);
		send_command(CMD_SEARCH, 32'hFFFF_FFFF);
		send_command(CMD_SEARCH, 32'd50);           // miss
		send_command(OP_NOP, 32'hFFFF_FFFF);        // unused code
		send_command(CMD_CLEAR, 32'h5A5A_A5A5);
		send_command(CMD_SEARCH, 32'd0);            // empty after clear

		// directed: ascending with a run of equal keys
		wait_idle();
		write_order(1'b0);
		send_command(CMD_APPEND, 32'hFFFF_FFFB);
		send_command(CMD_APPEND, 32'd3);
		send_command(CMD_APPEND, 32'd3);
		send_command(CMD_APPEND, 32'd3);
		send_command(CMD_APPEND, 32'd9);
		send_command(CMD_SEARCH, 32'd3);
		send_command(CMD_SEARCH, 32'hFFFF_FFFB);
		send_command(CMD_SEARCH, 32'd9);
		send_command(CMD_SEARCH, 32'd4);
		send_command(OP_NOP, 32'd0);

		// full table in both orders, the last appends dropped
		wait_idle();
		write_order(1'b1);
		table_round(DEPTH + 2, 12);
		wait_idle();
		write_order(1'b0);
		table_round(DEPTH + 2, 12);

		// long result hold while beats keep coming, fills the block up
		wait_idle();
		hold_cycles = HOLD_LEN;
		table_round(20, 30);

		// random rounds, order rewritten now and then between them
		while (sent_items < ITEM_TARGET) begin
			if (sent_items >= CALM_FROM)
				calm = 1'b1;
			if ($urandom_range(0, 2) == 0) begin
				wait_idle();
				write_order(1'($urandom_range(0, 1)));
			end
			table_round($urandom_range(0, 14), $urandom_range(1, 10));
		end

		// drain, then allow the search latency once more
		s_axis_tvalid <= 1'b0;
		while (sb.answers_due.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (sb.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

>>> sim.f
rtl/core/stbs_pkg.sv
rtl/core/stbs_front.sv
rtl/core/stbs_back.sv
rtl/core/sorted_table_binary_search.sv
tb/sv/testbench.sv
